### rtl/rcta_pkg.sv
// shared types and constants for the replay cache admission block
`default_nettype none
package rcta_pkg;

    localparam logic [1:0] REQ_SIGNED  = 2'd0;
    localparam logic [1:0] REQ_CONNECT = 2'd1;
    localparam logic [1:0] REQ_SWEEP   = 2'd2;

    localparam logic [1:0] DEC_ADMIT    = 2'd0;
    localparam logic [1:0] DEC_DUP      = 2'd1;
    localparam logic [1:0] DEC_CAPACITY = 2'd2;
    localparam logic [1:0] DEC_ZERO_KEY = 2'd3;

    localparam logic [1:0] CFG_TTL       = 2'd0;
    localparam logic [1:0] CFG_TOTAL     = 2'd1;
    localparam logic [1:0] CFG_PER_SIGNER = 2'd2;

    localparam logic [7:0] CONNECT_DOMAIN = 8'hff;
    localparam logic [63:0] TIME_MAX = 64'hffff_ffff_ffff_ffff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_LOOKUP,
        ST_COUNT,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

### rtl/rcta_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module rcta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/replay_cache_ttl_admission.sv
// top level of the replay cache with ttl admission
//  channel | direction | handshake           | fields
//  in      | input     | in_valid/in_stall   | req_type .. now_ms
//  out     | output    | out_valid/out_stall | decision, entry_count
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
// an admit scans the key memory one slot a cycle: optional sweep pass, lookup pass
// (ends early on a match; an unexpired match goes straight to the result) and count
// pass, then a decide state and the result state.
// an explicit sweep runs only the sweep pass; a zero key or reserved type goes to the result.
// reset clears valid bits (flip-flops) and the sweep due time; no memory clear.
// the result waits in an output register; in_stall is high from an accept until the
// result moves there, which waits while the previous result is still stalled.
`default_nettype none
module replay_cache_ttl_admission
    import rcta_pkg::*;
#(
    parameter int TABLE_SLOTS = 64,
    parameter int ID_BITS = 64,
    parameter int SWEEP_INTERVAL_MS = 1000
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  domain,
    input  wire logic [63:0] signer,
    input  wire logic [63:0] req_ident,
    input  wire logic [63:0] sess_ident,
    input  wire logic [63:0] init_nonce,
    input  wire logic        resp_nonce_on,
    input  wire logic [63:0] resp_nonce,
    input  wire logic        seq_on,
    input  wire logic [31:0] sequence_req,
    input  wire logic [63:0] now_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       decision,
    output logic [6:0]       entry_count,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    // domain, signer, request, session, inonce, rpres, rnonce, spres, seq (expiry added in MW)
    localparam int KW = 8 + 3*ID_BITS + 64 + 1 + 64 + 1 + 32;
    localparam int MW = KW + 64;
    localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

    state_t state_reg, state_next;

    logic [31:0] ttl_reg;
    logic [6:0]  total_lim_reg, per_lim_reg;
    logic [63:0] due_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;

    logic [1:0]  rt_reg;
    logic [KW-1:0] key_reg;
    logic [ID_BITS-1:0] sgn_reg;
    logic [63:0] now_reg;

    logic [AW-1:0] idx_reg;      // next scan address
    logic          rv_reg;       // read data valid for slot rd_idx_reg
    logic [AW-1:0] rd_idx_reg;
    logic [CW-1:0] per_reg;
    logic          free_found_reg;
    logic [AW-1:0] free_idx_reg;
    logic [1:0]    dec_reg;
    logic [6:0]    cnt_reg;
    logic          out_valid_reg;
    logic [1:0]    out_dec_reg;
    logic [6:0]    out_cnt_reg;

    logic          we;
    logic [AW-1:0] raddr;
    logic [MW-1:0] wdata, rdata;

    rcta_ram #(.WIDTH(MW), .DEPTH(TABLE_SLOTS)) u_ram (
        .clk(clk), .we(we), .waddr(free_idx_reg), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // incoming key, normalized
    logic conn;
    logic [KW-1:0] in_key;
    logic [ID_BITS-1:0] in_sgn, in_rq;
    logic zero_key;
    always_comb
    begin
        conn = (req_type == REQ_CONNECT);
        in_sgn = signer[ID_BITS-1:0];
        in_rq = req_ident[ID_BITS-1:0];
        in_key = {conn ? CONNECT_DOMAIN : domain, in_sgn, in_rq,
                  conn ? {ID_BITS{1'b0}} : sess_ident[ID_BITS-1:0],
                  conn ? 64'd0 : init_nonce,
                  (!conn && resp_nonce_on),
                  (!conn && resp_nonce_on) ? resp_nonce : 64'd0,
                  (!conn && seq_on),
                  (!conn && seq_on) ? sequence_req : 32'd0};
        zero_key = (in_sgn == '0) || (conn && in_rq == '0);
    end

    // stored slot fields
    logic [63:0] r_exp;
    logic [KW-1:0] r_key;
    logic [ID_BITS-1:0] r_sgn;
    logic r_live, r_expired, r_match;
    always_comb
    begin
        r_exp = rdata[63:0];
        r_key = rdata[MW-1:64];
        r_sgn = r_key[KW-9 -: ID_BITS];
        r_live = rv_reg && valid_reg[rd_idx_reg];
        r_expired = now_reg >= r_exp;
        r_match = (r_key == key_reg);
    end

    logic [64:0] exp_sum, due_sum;
    always_comb
    begin
        exp_sum = {1'b0, now_reg} + 65'(ttl_reg);
        due_sum = {1'b0, now_reg} + 65'(SWEEP_INTERVAL_MS);
        wdata = {key_reg, exp_sum[64] ? TIME_MAX : exp_sum[63:0]};
    end

    logic accept;
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign decision = out_dec_reg;
    assign entry_count = out_cnt_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_SWEEP)
                        state_next = ST_SWEEP;
                    else if (req_type == REQ_SIGNED || req_type == REQ_CONNECT)
                    begin
                        if (zero_key)
                            state_next = ST_OUT;
                        else if (now_ms >= due_reg)
                            state_next = ST_SWEEP;
                        else
                            state_next = ST_LOOKUP;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SWEEP:
                if (rv_reg && rd_idx_reg == LAST)
                    state_next = (rt_reg == REQ_SWEEP) ? ST_OUT : ST_LOOKUP;
            ST_LOOKUP:
                if (rv_reg && (rd_idx_reg == LAST || (r_live && r_match)))
                    state_next = (r_live && r_match && !r_expired) ? ST_OUT : ST_COUNT;
            ST_COUNT:
                if (rv_reg && rd_idx_reg == LAST)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // scan address: a new pass reads slot 0 right away
    logic scan_start, scan_more;
    always_comb
    begin
        scan_start = (state_next != state_reg)
                     && (state_next == ST_SWEEP || state_next == ST_LOOKUP
                         || state_next == ST_COUNT);
        scan_more = (state_next == state_reg)
                    && (state_reg == ST_SWEEP || state_reg == ST_LOOKUP
                        || state_reg == ST_COUNT);
        raddr = scan_start ? '0 : idx_reg;
    end

    // insert write
    logic total_ok;
    always_comb
    begin
        total_ok = (7'(CW'($countones(valid_reg))) < total_lim_reg);
        we = (state_reg == ST_DECIDE) && free_found_reg && total_ok
             && (32'(per_reg) < 32'(per_lim_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ttl_reg <= 32'd30000;
            total_lim_reg <= 7'd64;
            per_lim_reg <= 7'd16;
            due_reg <= '0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            rv_reg <= 1'b0;
            idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TTL:        ttl_reg <= cfg_data;
                    CFG_TOTAL:      total_lim_reg <= cfg_data[6:0];
                    CFG_PER_SIGNER: per_lim_reg <= cfg_data[6:0];
                    default:        ;
                endcase
            end
            case (state_reg)
                ST_SWEEP:
                begin
                    if (r_live && r_expired)
                        valid_reg[rd_idx_reg] <= 1'b0;
                end
                ST_LOOKUP:
                begin
                    if (r_live && r_match && r_expired)
                        valid_reg[rd_idx_reg] <= 1'b0;
                end
                ST_DECIDE:
                begin
                    if (we)
                        valid_reg[free_idx_reg] <= 1'b1;
                end
                default: ;
            endcase
            // scan address walk shared by the three passes
            if (scan_start)
            begin
                idx_reg <= AW'(1);
                rd_idx_reg <= '0;
                rv_reg <= 1'b1;
            end
            else if (scan_more)
            begin
                idx_reg <= idx_reg + AW'(1);
                rd_idx_reg <= idx_reg;
                rv_reg <= 1'b1;
            end
            else
            begin
                rv_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            // throttled sweep sets the next due time
            if (state_reg == ST_SWEEP && state_next != ST_SWEEP && rt_reg != REQ_SWEEP)
                due_reg <= due_sum[64] ? TIME_MAX : due_sum[63:0];
        end
    end

    // payload and scan accumulators
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            rt_reg <= req_type;
            key_reg <= in_key;
            sgn_reg <= in_sgn;
            now_reg <= now_ms;
            dec_reg <= zero_key && (req_type == REQ_SIGNED || req_type == REQ_CONNECT)
                       ? DEC_ZERO_KEY : DEC_ADMIT;
        end
        if (state_reg == ST_LOOKUP && state_next == ST_COUNT)
        begin
            per_reg <= '0;
            free_found_reg <= 1'b0;
        end
        if (state_reg == ST_LOOKUP && state_next == ST_OUT)
            dec_reg <= DEC_DUP;
        if (state_reg == ST_COUNT && rv_reg)
        begin
            if (valid_reg[rd_idx_reg])
            begin
                if (r_sgn == sgn_reg)
                    per_reg <= per_reg + CW'(1);
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (state_reg == ST_DECIDE)
            dec_reg <= we ? DEC_ADMIT : DEC_CAPACITY;
        if (state_next == ST_OUT && state_reg != ST_OUT && state_reg != ST_DECIDE)
            cnt_reg <= 7'(CW'($countones(valid_reg)
                       - ((state_reg == ST_SWEEP || state_reg == ST_LOOKUP)
                          && r_live && r_expired ? 1 : 0)));
        if (state_reg == ST_DECIDE)
            cnt_reg <= 7'(CW'($countones(valid_reg) + (we ? 1 : 0)));
        // result moves to the output register
        if (state_reg == ST_OUT && state_next == ST_IDLE)
        begin
            out_dec_reg <= dec_reg;
            out_cnt_reg <= cnt_reg;
        end
    end
endmodule
`default_nettype wire
